// File: rtl/ssem_pkg.sv
package ssem_pkg;

   localparam int WORD_BITS   = 32;
   localparam int STORE_LINES = 32;
   localparam int LINE_BITS   = 5;
   localparam int OP_BITS     = 3;
   localparam int OP_LSB      = 13;
   localparam int KIND_BITS   = 2;

   // Item kinds
   localparam logic [KIND_BITS-1:0] KIND_WRITE   = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_EXEC    = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_RESTART = 2'd2;

   // Opcodes, bits 13-15 of the instruction word
   localparam logic [OP_BITS-1:0] OP_JMP     = 3'd0;
   localparam logic [OP_BITS-1:0] OP_JRP     = 3'd1;
   localparam logic [OP_BITS-1:0] OP_LDN     = 3'd2;
   localparam logic [OP_BITS-1:0] OP_STO     = 3'd3;
   localparam logic [OP_BITS-1:0] OP_SUB     = 3'd4;
   localparam logic [OP_BITS-1:0] OP_SUB_ALT = 3'd5;
   localparam logic [OP_BITS-1:0] OP_CMP     = 3'd6;
   localparam logic [OP_BITS-1:0] OP_STP     = 3'd7;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [LINE_BITS-1:0] line_type;
   typedef logic [OP_BITS-1:0]   opcode_type;

   // Outcome of one item as computed by the execute unit
   typedef struct packed {
      line_type   counter;
      word_type   acc;
      logic       halt;
      logic       wr_en;
      line_type   wr_addr;
      word_type   wr_data;
      word_type   instr;
      opcode_type opcode;
   } exec_result_type;

endpackage

// File: rtl/ssem_req_if.sv
interface ssem_req_if import ssem_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [KIND_BITS-1:0] kind;
   line_type             address;
   word_type             data;

   modport source (output valid, output kind, output address, output data, input ready);
   modport sink (input valid, input kind, input address, input data, output ready);
endinterface

// File: rtl/ssem_rsp_if.sv
interface ssem_rsp_if import ssem_pkg::*;;
   logic       valid;
   logic       ready;
   line_type   program_counter;
   word_type   acc_value;
   word_type   present_instruction;
   opcode_type executed_opcode;
   logic       halted;

   modport source (
      output valid, output program_counter, output acc_value,
      output present_instruction, output executed_opcode, output halted,
      input ready
   );
   modport sink (
      input valid, input program_counter, input acc_value,
      input present_instruction, input executed_opcode, input halted,
      output ready
   );
endinterface

// File: rtl/ssem_ram.sv
module ssem_ram #(
   parameter int WIDTH     = 32,
   parameter int DEPTH     = 32,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the old word when the same line is written in that cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/ssem_exec.sv
module ssem_exec import ssem_pkg::*; (
   input  logic [KIND_BITS-1:0] kind,
   input  line_type             address,
   input  word_type             data,
   input  word_type             instr,
   input  word_type             operand,
   input  line_type             counter,
   input  word_type             acc,
   input  logic                 halt,
   output exec_result_type      result
);

   opcode_type opc;
   line_type   pc_mid;

   assign opc = instr[OP_LSB +: OP_BITS];

   always_comb begin
      result         = '0;
      result.counter = counter;
      result.acc     = acc;
      result.halt    = halt;
      result.wr_addr = address;
      result.wr_data = data;
      pc_mid         = counter;
      unique case (kind)
         KIND_WRITE: begin
            result.wr_en = 1'b1;
         end
         KIND_RESTART: begin
            result.counter = '0;
            result.acc     = '0;
            result.halt    = 1'b0;
         end
         KIND_EXEC: begin
            if (!halt) begin
               result.instr  = instr;
               result.opcode = opc;
               unique case (opc) inside
                  OP_JMP: pc_mid = operand[LINE_BITS-1:0];
                  OP_JRP: pc_mid = counter + operand[LINE_BITS-1:0];
                  OP_LDN: result.acc = word_type'(0) - operand;
                  OP_STO: begin
                     result.wr_en   = 1'b1;
                     result.wr_addr = instr[LINE_BITS-1:0];
                     result.wr_data = acc;
                  end
                  OP_SUB, OP_SUB_ALT: result.acc = acc - operand;
                  OP_CMP: begin
                     if (acc[WORD_BITS-1]) begin
                        pc_mid = counter + line_type'(1);
                     end
                  end
                  OP_STP: result.halt = 1'b1;
                  default: pc_mid = counter;
               endcase
               // advance past the instruction unless it stopped the machine
               result.counter = (opc != OP_STP) ? pc_mid + line_type'(1) : pc_mid;
            end
         end
         default: begin
            result.wr_en = 1'b0;
         end
      endcase
   end

endmodule

// File: rtl/ssem_instruction_executor.sv
// A result is registered after its item passes the fetch and execute states;
// a new item is taken only as the last one retires, since the single store
// read port serves the instruction fetch first, then the operand read.
// Reset (synchronous, active high) clears the counter, accumulator and stop
// flag, and marks every store line unwritten so that it reads as zero.
module ssem_instruction_executor import ssem_pkg::*; (
   input logic        clock,
   input logic        reset,
   ssem_req_if.sink   req_ch,
   ssem_rsp_if.source rsp_ch
);

   // Sequencer codes
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   logic [1:0]           state_ff, state_in;

   // Item held while it is worked on
   logic [KIND_BITS-1:0] kind_ff;
   line_type             address_ff;
   word_type             data_ff;
   word_type             instr_ff, instr_in;

   // Architectural registers
   line_type             counter_ff, counter_in;
   word_type             acc_ff, acc_in;
   logic                 halt_ff, halt_in;

   // Per-line written flags; an unwritten line reads as zero
   logic [STORE_LINES-1:0] written_ff, written_in;

   // Store port and forwarding
   line_type             rd_addr;
   word_type             ram_q;
   word_type             rd_word;
   logic                 rd_written_ff, rd_written_in;
   logic                 fwd_hit_ff, fwd_hit_in;
   word_type             fwd_data_ff;
   logic                 wr_en;

   // Result register
   logic                 rsp_valid_ff, rsp_valid_in;
   line_type             rsp_pc_ff;
   word_type             rsp_acc_ff;
   word_type             rsp_instr_ff;
   opcode_type           rsp_opc_ff;
   logic                 rsp_halt_ff;

   exec_result_type      res;
   logic                 exec_go, exec_fire, accept;

   // The item in its last cycle retires only when the result slot is free
   // or is being emptied in the same cycle.
   assign exec_go   = !rsp_valid_ff || rsp_ch.ready;
   assign exec_fire = (state_ff == ST_EXEC) && exec_go;

   // Take a new item while idle, or in the cycle the previous one retires
   assign req_ch.ready = (state_ff == ST_IDLE) || exec_fire;
   assign accept       = req_ch.valid && req_ch.ready;

   // Word seen on the read port: a write to the same line in the read cycle
   // wins, then an unwritten line reads as zero.
   assign rd_word = fwd_hit_ff ? fwd_data_ff : (rd_written_ff ? ram_q : '0);

   ssem_exec u_exec (
      .kind    (kind_ff),
      .address (address_ff),
      .data    (data_ff),
      .instr   (instr_ff),
      .operand (rd_word),
      .counter (counter_ff),
      .acc     (acc_ff),
      .halt    (halt_ff),
      .result  (res)
   );

   assign wr_en = exec_fire && res.wr_en;

   // Read address: fetch at the counter (forwarded from a retiring item),
   // then the operand line; while stalled, keep re-reading the operand.
   always_comb begin
      rd_addr = counter_ff;
      unique case (state_ff)
         ST_IDLE:  rd_addr = counter_ff;
         ST_FETCH: rd_addr = rd_word[LINE_BITS-1:0];
         ST_EXEC:  rd_addr = exec_go ? res.counter : instr_ff[LINE_BITS-1:0];
         default:  rd_addr = counter_ff;
      endcase
   end

   ssem_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (STORE_LINES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (res.wr_addr),
      .wr_data (res.wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      written_in = written_ff;
      if (wr_en) begin
         written_in[res.wr_addr] = 1'b1;
      end
      rd_written_in = written_ff[rd_addr];
      fwd_hit_in    = wr_en && (res.wr_addr == rd_addr);
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  state_in = accept ? ST_FETCH : ST_IDLE;
         ST_FETCH: state_in = ST_EXEC;
         ST_EXEC: begin
            if (exec_fire) begin
               state_in = accept ? ST_FETCH : ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Latch the instruction as it arrives; hold it through any stall
   assign instr_in = (state_ff == ST_FETCH) ? rd_word : instr_ff;

   // Commit architectural state when the item retires
   always_comb begin
      counter_in = counter_ff;
      acc_in     = acc_ff;
      halt_in    = halt_ff;
      if (exec_fire) begin
         counter_in = res.counter;
         acc_in     = res.acc;
         halt_in    = res.halt;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         counter_ff    <= '0;
         acc_ff        <= '0;
         halt_ff       <= 1'b0;
         written_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         rd_written_ff <= 1'b0;
         fwd_hit_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         counter_ff    <= counter_in;
         acc_ff        <= acc_in;
         halt_ff       <= halt_in;
         written_ff    <= written_in;
         rsp_valid_ff  <= rsp_valid_in;
         rd_written_ff <= rd_written_in;
         fwd_hit_ff    <= fwd_hit_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      fwd_data_ff <= res.wr_data;
      instr_ff    <= instr_in;
      if (accept) begin
         kind_ff    <= req_ch.kind;
         address_ff <= req_ch.address;
         data_ff    <= req_ch.data;
      end
      if (exec_fire) begin
         rsp_pc_ff    <= res.counter;
         rsp_acc_ff   <= res.acc;
         rsp_instr_ff <= res.instr;
         rsp_opc_ff   <= res.opcode;
         rsp_halt_ff  <= res.halt;
      end
   end

   assign rsp_ch.valid               = rsp_valid_ff;
   assign rsp_ch.program_counter     = rsp_pc_ff;
   assign rsp_ch.acc_value           = rsp_acc_ff;
   assign rsp_ch.present_instruction = rsp_instr_ff;
   assign rsp_ch.executed_opcode     = rsp_opc_ff;
   assign rsp_ch.halted              = rsp_halt_ff;

endmodule
